// ===== src/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg: shared constants and types for the safe allocator
// Operation and status codes, resource count, parameter defaults and the
// write controls of the claim/holding store.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int NRES               = 3;
    localparam int NUM_PROCS_DEFAULT  = 4;
    localparam int COUNT_BITS_DEFAULT = 8;

    localparam int FIELD_W    = 8;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_GRANTED  = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_BAD_PROC = 3'd3;
    localparam logic [2:0] ST_BAD_AMT  = 3'd4;
    localparam logic [2:0] ST_UNSAFE   = 3'd5;

    localparam logic [2:0] COUNT_SAT = 3'd7;

    typedef struct packed {
        logic claim_we;
        logic held_we;
    } bsa_wr_t;

endpackage

// ===== src/bankers_safe_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bankers_safe_allocator_core: deadlock-avoiding resource allocator
// Keeps claim, holding, available units and active flags for a set of
// processes over three resource types; loads processes, sets the pool and
// grants requests only when every active process can still finish.
//
//   Channel  Direction  Beat
//   s_       in         one operation request (op, proc, amounts, claims)
//   m_       out        one result per request (status, pool, active count)
//
// Load, set and unused codes go from S_EXEC straight to S_RESP, which
// registers the result. A request runs the safety scan between S_EXEC and
// S_DECIDE: the scan visits one process per cycle through the shared fit
// unit, pass after pass until a pass frees nothing or all are done.
// s_tready is high only while the sequencer is idle; a result held by a low
// m_tready stalls the sequencer. Reset clears the pool and active flags.
// ----------------------------------------------------------------------------
module bankers_safe_allocator_core
    import bsa_pkg::*;
#(
    parameter int NUM_PROCS  = NUM_PROCS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op[1:0], proc[3:2], amount_0[11:4], amount_1[19:12], amount_2[27:20],
    // claim_0[35:28], claim_1[43:36], claim_2[51:44], zero[55:52]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[2:0], avail_out_0[10:3], avail_out_1[18:11], avail_out_2[26:19],
    // active_count[29:27], zero[31:30]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W  = $clog2(NUM_PROCS);
    localparam int CNT_W  = $clog2(NUM_PROCS + 1);
    localparam int WORK_W = COUNT_BITS + CNT_W;
    localparam int CMP_W  = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                      op_reg, op_next;
    logic [1:0]                      proc_reg, proc_next;
    logic [NRES-1:0][FIELD_W-1:0]    amt_reg, amt_next;
    logic [NRES-1:0][FIELD_W-1:0]    claim_in_reg, claim_in_next;
    logic [NRES-1:0][COUNT_BITS-1:0] avail_reg, avail_next;
    logic [NUM_PROCS-1:0]            active_reg, active_next;
    logic [NRES-1:0][WORK_W-1:0]     work_reg, work_next;
    logic [NUM_PROCS-1:0]            done_reg, done_next;
    logic [IDX_W-1:0]                scan_idx_reg, scan_idx_next;
    logic                            progress_reg, progress_next;
    logic [2:0]                      status_reg, status_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]            m_tdata_reg, m_tdata_next;

    logic [IDX_W-1:0]                proc_idx;
    logic [IDX_W-1:0]                idx;
    logic                            proc_ok;
    bsa_wr_t                         wr_ctl;
    logic [NRES-1:0][COUNT_BITS-1:0] wr_claim;
    logic [NRES-1:0][COUNT_BITS-1:0] wr_held;
    logic [NRES-1:0][COUNT_BITS-1:0] rd_claim;
    logic [NRES-1:0][COUNT_BITS-1:0] rd_held;
    logic                            fits;
    logic [NRES-1:0][WORK_W-1:0]     work_sum;

    logic [NRES-1:0][COUNT_BITS-1:0] need;
    logic [NRES-1:0][COUNT_BITS-1:0] amt_cb;
    logic [NRES-1:0][COUNT_BITS-1:0] claim_cb;
    logic                            load_bad;
    logic                            req_bad;
    logic                            full;
    logic [NRES-1:0][COUNT_BITS:0]   release_sum;
    logic [CNT_W-1:0]                active_cnt;
    logic [2:0]                      active_sat;
    logic                            scan_take;
    logic [NUM_PROCS-1:0]            done_upd;

    assign proc_idx = IDX_W'(proc_reg);
    assign proc_ok  = (32'(proc_reg) < NUM_PROCS);
    assign idx      = (state_reg == S_SCAN) ? scan_idx_reg : proc_idx;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    bsa_store #(
        .NUM_PROCS  (NUM_PROCS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .aclk     (aclk),
        .idx      (idx),
        .wr_ctl   (wr_ctl),
        .wr_claim (wr_claim),
        .wr_held  (wr_held),
        .rd_claim (rd_claim),
        .rd_held  (rd_held)
    );

    bsa_fit_unit #(
        .COUNT_BITS (COUNT_BITS),
        .WORK_W     (WORK_W)
    ) u_fit (
        .claim_row (rd_claim),
        .held_row  (rd_held),
        .work      (work_reg),
        .fits      (fits),
        .work_sum  (work_sum)
    );

    // load and request checks, and release arithmetic on the row at the request index
    always_comb begin
        load_bad = 1'b0;
        req_bad  = 1'b0;
        full     = 1'b1;
        for (int r = 0; r < NRES; r++) begin
            amt_cb[r]      = COUNT_BITS'(amt_reg[r]);
            claim_cb[r]    = COUNT_BITS'(claim_in_reg[r]);
            need[r]        = rd_claim[r] - rd_held[r];
            release_sum[r] = {1'b0, avail_reg[r]} + {1'b0, rd_held[r]};
            if (amt_cb[r] > claim_cb[r]) begin
                load_bad = 1'b1;
            end
            if ((CMP_W'(amt_reg[r]) > CMP_W'(need[r])) ||
                (CMP_W'(amt_reg[r]) > CMP_W'(avail_reg[r]))) begin
                req_bad = 1'b1;
            end
            if (rd_held[r] != rd_claim[r]) begin
                full = 1'b0;
            end
        end
    end

    always_comb begin
        active_cnt = '0;
        for (int p = 0; p < NUM_PROCS; p++) begin
            active_cnt = active_cnt + CNT_W'(active_reg[p]);
        end
        active_sat = (32'(active_cnt) > 32'(COUNT_SAT)) ? COUNT_SAT : 3'(active_cnt);
    end

    assign scan_take = !done_reg[scan_idx_reg] && fits;

    always_comb begin
        done_upd = done_reg;
        if (scan_take) begin
            done_upd[scan_idx_reg] = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        proc_next     = proc_reg;
        amt_next      = amt_reg;
        claim_in_next = claim_in_reg;
        avail_next    = avail_reg;
        active_next   = active_reg;
        work_next     = work_reg;
        done_next     = done_reg;
        scan_idx_next = scan_idx_reg;
        progress_next = progress_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_ctl        = '0;
        wr_claim      = claim_cb;
        wr_held       = amt_cb;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next       = s_tdata[1:0];
                    proc_next     = s_tdata[3:2];
                    amt_next      = s_tdata[27:4];
                    claim_in_next = s_tdata[51:28];
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next  = S_RESP;
                status_next = ST_OK;
                unique case (op_reg)
                    OP_LOAD: begin
                        if (!proc_ok) begin
                            status_next = ST_BAD_PROC;
                        end else if (load_bad) begin
                            status_next = ST_BAD_AMT;
                        end else begin
                            wr_ctl.claim_we       = 1'b1;
                            wr_ctl.held_we        = 1'b1;
                            active_next[proc_idx] = 1'b1;
                        end
                    end
                    OP_SET: begin
                        avail_next = amt_cb;
                    end
                    OP_REQUEST: begin
                        if (!proc_ok || !active_reg[proc_idx]) begin
                            status_next = ST_BAD_PROC;
                        end else if (req_bad) begin
                            status_next = ST_BAD_AMT;
                        end else begin
                            // grant tentatively, then start the safety scan
                            wr_ctl.held_we = 1'b1;
                            for (int r = 0; r < NRES; r++) begin
                                wr_held[r]    = rd_held[r] + amt_cb[r];
                                avail_next[r] = avail_reg[r] - amt_cb[r];
                                work_next[r]  = WORK_W'(avail_next[r]);
                            end
                            done_next     = ~active_reg;
                            scan_idx_next = '0;
                            progress_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                if (scan_take) begin
                    work_next = work_sum;
                end
                done_next = done_upd;
                if (scan_idx_reg == IDX_W'(NUM_PROCS - 1)) begin
                    // another pass only if this one freed someone and some are not yet done
                    if ((progress_reg || scan_take) && !(&done_upd)) begin
                        scan_idx_next = '0;
                        progress_next = 1'b0;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    progress_next = progress_reg || scan_take;
                end
            end
            S_DECIDE: begin
                state_next = S_RESP;
                if (!(&done_reg)) begin
                    // roll back the tentative grant
                    wr_ctl.held_we = 1'b1;
                    for (int r = 0; r < NRES; r++) begin
                        wr_held[r]    = rd_held[r] - amt_cb[r];
                        avail_next[r] = avail_reg[r] + amt_cb[r];
                    end
                    status_next = ST_UNSAFE;
                end else if (full) begin
                    wr_ctl.held_we = 1'b1;
                    for (int r = 0; r < NRES; r++) begin
                        wr_held[r]    = '0;
                        avail_next[r] = release_sum[r][COUNT_BITS] ? '1 :
                                        release_sum[r][COUNT_BITS-1:0];
                    end
                    active_next[proc_idx] = 1'b0;
                    status_next           = ST_COMPLETE;
                end else begin
                    status_next = ST_GRANTED;
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, active_sat,
                                     FIELD_W'(avail_reg[2]),
                                     FIELD_W'(avail_reg[1]),
                                     FIELD_W'(avail_reg[0]),
                                     status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            avail_reg    <= '0;
            active_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            avail_reg    <= avail_next;
            active_reg   <= active_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        proc_reg     <= proc_next;
        amt_reg      <= amt_next;
        claim_in_reg <= claim_in_next;
        work_reg     <= work_next;
        done_reg     <= done_next;
        scan_idx_reg <= scan_idx_next;
        progress_reg <= progress_next;
        status_reg   <= status_next;
    end

endmodule

// ===== src/bsa_store.sv =====
// ----------------------------------------------------------------------------
// bsa_store: per-process claim and holding rows
// One row of three counts per process for claim and for holding, written
// and read at a single shared index.
// ----------------------------------------------------------------------------
module bsa_store
    import bsa_pkg::*;
#(
    parameter int NUM_PROCS  = NUM_PROCS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
    localparam int IDX_W     = $clog2(NUM_PROCS)
) (
    input  logic                                aclk,
    input  logic [IDX_W-1:0]                    idx,
    input  bsa_wr_t                             wr_ctl,
    input  logic [NRES-1:0][COUNT_BITS-1:0]     wr_claim,
    input  logic [NRES-1:0][COUNT_BITS-1:0]     wr_held,
    output logic [NRES-1:0][COUNT_BITS-1:0]     rd_claim,
    output logic [NRES-1:0][COUNT_BITS-1:0]     rd_held
);

    logic [NRES-1:0][COUNT_BITS-1:0] claim_reg [NUM_PROCS];
    logic [NRES-1:0][COUNT_BITS-1:0] held_reg  [NUM_PROCS];

    // row contents only take effect for processes that a load has made active
    always_ff @(posedge aclk) begin
        if (wr_ctl.claim_we) begin
            claim_reg[idx] <= wr_claim;
        end
        if (wr_ctl.held_we) begin
            held_reg[idx] <= wr_held;
        end
    end

    assign rd_claim = claim_reg[idx];
    assign rd_held  = held_reg[idx];

endmodule

// ===== src/bsa_fit_unit.sv =====
// ----------------------------------------------------------------------------
// bsa_fit_unit: one safety-scan step
// Checks whether one process's remaining need fits the work vector and
// forms the work vector after that process hands back its holding.
// ----------------------------------------------------------------------------
module bsa_fit_unit
    import bsa_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
    parameter int WORK_W     = COUNT_BITS_DEFAULT + 3
) (
    input  logic [NRES-1:0][COUNT_BITS-1:0] claim_row,
    input  logic [NRES-1:0][COUNT_BITS-1:0] held_row,
    input  logic [NRES-1:0][WORK_W-1:0]     work,
    output logic                            fits,
    output logic [NRES-1:0][WORK_W-1:0]     work_sum
);

    logic [NRES-1:0][COUNT_BITS-1:0] need;

    always_comb begin
        fits = 1'b1;
        for (int r = 0; r < NRES; r++) begin
            need[r]     = claim_row[r] - held_row[r];
            work_sum[r] = work[r] + WORK_W'(held_row[r]);
            if (WORK_W'(need[r]) > work[r]) begin
                fits = 1'b0;
            end
        end
    end

endmodule
